[rtl/ocu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocu_pkg
// Types, constants and the arctangent table shared by the orbit camera update.
// ----------------------------------------------------------------------------
package ocu_pkg;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE, ST_YAW1, ST_YAW2, ST_YAW3, ST_PIT1, ST_PIT2, ST_PIT3,
      ST_DIFF, ST_SQX, ST_SQY, ST_SQZ, ST_SQSUM, ST_SQRT, ST_RAD,
      ST_CINIT, ST_CITER, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_OUT
   } state_type;

   localparam int CORDIC_ITERATIONS_DEFAULT = 16;

   // Q3.13 angle constants
   localparam logic signed [17:0] PI_Q13        = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13    = 18'sd51472;
   localparam logic signed [17:0] HALF_PI_Q13   = 18'sd12868;
   localparam logic signed [17:0] PITCH_LIM_Q13 = 18'sd9651;

   // reset values
   localparam logic [15:0]        SENS_RESET = 16'd655;
   localparam logic signed [31:0] CAM_RESET  = 32'sd131072;

   // cordic gain in Q2.30
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

   // atan(2^-i) in Q2.30
   function automatic logic [30:0] atan_q30(input logic [5:0] i);
      logic [30:0] v;
      case (i)
         6'd0:    v = 31'd843314857;
         6'd1:    v = 31'd497837829;
         6'd2:    v = 31'd263043837;
         6'd3:    v = 31'd133525159;
         6'd4:    v = 31'd67021688;
         6'd5:    v = 31'd33543516;
         6'd6:    v = 31'd16775851;
         6'd7:    v = 31'd8388437;
         6'd8:    v = 31'd4194283;
         6'd9:    v = 31'd2097149;
         default: begin
            if (i <= 6'd30) v = 31'd1 << (6'd30 - i);
            else v = 31'd0;
         end
      endcase
      return v;
   endfunction

endpackage

[rtl/orbit_camera_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_camera_update_top
// Spherical orbit camera: pointer deltas turn yaw and pitch, and an orbit item
// moves the camera around a centre at its current distance.
// ----------------------------------------------------------------------------
// One item is worked on at a time; req_stall stays high from acceptance until
// the result is loaded into the output register. An angles-only item (kind 0)
// runs only the yaw and pitch steps; an orbit item also runs the 32-step square
// root and the two sine/cosine runs of the single cordic unit. All products go
// through one shared 33x33-bit multiplier, one product per cycle. A result waits
// in the output register until taken; sensitivity is to be written through
// csr_write/csr_wdata only when idle, which the block itself does not enforce.
module orbit_camera_update_top #(
   parameter int CORDIC_ITERATIONS = ocu_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [10:0] req_delta_x,
   input  logic signed [10:0] req_delta_y,
   input  logic signed [31:0] req_centre_x,
   input  logic signed [31:0] req_centre_y,
   input  logic signed [31:0] req_centre_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic [15:0]        rsp_yaw_angle,
   output logic signed [14:0] rsp_pitch_angle
);
   import ocu_pkg::*;

   localparam int IW = $clog2(CORDIC_ITERATIONS + 1);
   localparam logic [IW-1:0] IT_LAST = IW'(CORDIC_ITERATIONS - 1);

   state_type state_ff, state_in;

   // config and architectural state
   logic [15:0]        sens_ff, sens_in;
   logic [15:0]        yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic signed [31:0] cam_x_ff, cam_x_in, cam_y_ff, cam_y_in, cam_z_ff, cam_z_in;

   // latched item
   logic               kind_ff, kind_in;
   logic signed [10:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [31:0] ctx_ff, ctx_in, cty_ff, cty_in, ctz_ff, ctz_in;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;

   // radius
   logic [30:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic        half_ff, half_in;
   logic [63:0] acc_ff, acc_in, v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [30:0] rr_ff, rr_in;

   // cordic
   logic signed [33:0] cx_ff, cx_in, cyv_ff, cyv_in, cz_ff, cz_in;
   logic [IW-1:0]      it_ff, it_in;
   logic               neg_ff, neg_in, phase_ff, phase_in;
   logic signed [32:0] cos_y_ff, cos_y_in, sin_y_ff, sin_y_in;
   logic signed [32:0] cos_p_ff, cos_p_in, sin_p_ff, sin_p_in;
   logic signed [32:0] rcp_ff, rcp_in;

   // output register
   logic               out_v_ff, out_v_in;
   logic signed [31:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_z_ff, o_z_in;
   logic [15:0]        o_yaw_ff, o_yaw_in;
   logic signed [14:0] o_pitch_ff, o_pitch_in;

   // combinational temporaries
   logic [11:0]        mag;
   logic [42:0]        step_sum;
   logic signed [27:0] step_s, ang_new;
   logic signed [32:0] dd_x, dd_y, dd_z;
   logic [32:0]        ab_x, ab_y, ab_z;
   logic [63:0]        trial;
   logic [32:0]        r_sh;
   logic signed [17:0] fold;
   logic signed [33:0] xs, ys, x_nx, y_nx;
   logic [30:0]        at;
   logic signed [65:0] rnd_sum;
   logic signed [35:0] rnd;
   logic signed [36:0] pos_sum;
   logic signed [31:0] pos_sat;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_YAW1;
         ST_YAW1:  state_in = ST_YAW2;
         ST_YAW2:  state_in = ST_YAW3;
         ST_YAW3:  state_in = ST_PIT1;
         ST_PIT1:  state_in = ST_PIT2;
         ST_PIT2:  state_in = ST_PIT3;
         ST_PIT3:  state_in = kind_ff ? ST_DIFF : ST_OUT;
         ST_DIFF:  state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_SQZ;
         ST_SQZ:   state_in = ST_SQSUM;
         ST_SQSUM: state_in = ST_SQRT;
         ST_SQRT:  if (bit_ff[0]) state_in = ST_RAD;
         ST_RAD:   state_in = ST_CINIT;
         ST_CINIT: state_in = ST_CITER;
         ST_CITER: if (it_ff == IT_LAST) state_in = phase_ff ? ST_M1 : ST_CINIT;
         ST_M1:    state_in = ST_M2;
         ST_M2:    state_in = ST_M3;
         ST_M3:    state_in = ST_M4;
         ST_M4:    state_in = ST_M5;
         ST_M5:    state_in = ST_OUT;
         ST_OUT:   if (!out_v_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // rounding of the registered product by 2^30, half up
   assign rnd_sum = prod_ff + (66'sd1 <<< 29);
   assign rnd     = rnd_sum[65:30];

   // datapath and outputs
   always_comb begin
      sens_in = csr_write ? csr_wdata : sens_ff;
      yaw_in = yaw_ff;     pitch_in = pitch_ff;
      cam_x_in = cam_x_ff; cam_y_in = cam_y_ff; cam_z_in = cam_z_ff;
      kind_in = kind_ff;   dx_in = dx_ff;       dy_in = dy_ff;
      ctx_in = ctx_ff;     cty_in = cty_ff;     ctz_in = ctz_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff; half_in = half_ff;
      acc_in = acc_ff; v_in = v_ff; r_in = r_ff; bit_in = bit_ff; rr_in = rr_ff;
      cx_in = cx_ff; cyv_in = cyv_ff; cz_in = cz_ff; it_in = it_ff;
      neg_in = neg_ff; phase_in = phase_ff;
      cos_y_in = cos_y_ff; sin_y_in = sin_y_ff;
      cos_p_in = cos_p_ff; sin_p_in = sin_p_ff; rcp_in = rcp_ff;
      out_v_in = out_v_ff && rsp_stall;
      o_x_in = o_x_ff; o_y_in = o_y_ff; o_z_in = o_z_ff;
      o_yaw_in = o_yaw_ff; o_pitch_in = o_pitch_ff;
      mul_a = '0; mul_b = '0;
      req_stall = (state_ff != ST_IDLE);

      // angle step magnitude
      mag = (state_ff == ST_YAW1) ? (dx_ff[10] ? 12'(-13'(dx_ff)) : 12'(dx_ff))
                                  : (dy_ff[10] ? 12'(-13'(dy_ff)) : 12'(dy_ff));
      step_sum = prod_ff[42:0] + 43'd32768;
      step_s = ((state_ff == ST_YAW3) ? dx_ff[10] : dy_ff[10])
               ? -28'sd0 - $signed({1'b0, step_sum[42:16]})
               : $signed({1'b0, step_sum[42:16]});
      ang_new = '0;

      // radius helpers
      dd_x = 33'(cam_x_ff) - 33'(ctx_ff);
      dd_y = 33'(cam_y_ff) - 33'(cty_ff);
      dd_z = 33'(cam_z_ff) - 33'(ctz_ff);
      ab_x = dd_x[32] ? 33'(-dd_x) : 33'(dd_x);
      ab_y = dd_y[32] ? 33'(-dd_y) : 33'(dd_y);
      ab_z = dd_z[32] ? 33'(-dd_z) : 33'(dd_z);
      trial = r_ff + bit_ff;
      r_sh = half_ff ? {r_ff[31:0], 1'b0} : {1'b0, r_ff[31:0]};

      // cordic fold of angle + pi into -pi..pi
      fold = (phase_ff ? 18'(pitch_ff) : $signed({2'b00, yaw_ff})) + PI_Q13;
      if (fold > PI_Q13) fold = fold - TWO_PI_Q13;
      if (fold < -PI_Q13) fold = fold + TWO_PI_Q13;

      // cordic rotation step
      xs = cx_ff >>> it_ff;
      ys = cyv_ff >>> it_ff;
      at = atan_q30(6'(it_ff));
      x_nx = cz_ff[33] ? cx_ff + ys : cx_ff - ys;
      y_nx = cz_ff[33] ? cyv_ff - xs : cyv_ff + xs;

      pos_sum = '0;
      pos_sat = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind; dx_in = req_delta_x; dy_in = req_delta_y;
               ctx_in = req_centre_x; cty_in = req_centre_y; ctz_in = req_centre_z;
            end
         end
         ST_YAW1, ST_PIT1: begin
            mul_a = $signed({17'd0, sens_ff});
            mul_b = $signed({21'd0, mag});
         end
         ST_YAW2, ST_PIT2: begin
            mul_a = prod_ff[32:0];
            mul_b = 33'(PI_Q13);
         end
         ST_YAW3: begin
            ang_new = $signed({12'd0, yaw_ff}) + step_s;
            if (ang_new < 0) ang_new = ang_new + 28'(TWO_PI_Q13);
            else if (ang_new > 28'(TWO_PI_Q13)) ang_new = ang_new - 28'(TWO_PI_Q13);
            if (ang_new < 0) ang_new = '0;
            if (ang_new > 28'(TWO_PI_Q13)) ang_new = 28'(TWO_PI_Q13);
            yaw_in = ang_new[15:0];
         end
         ST_PIT3: begin
            ang_new = 28'(pitch_ff) + step_s;
            if (ang_new < -28'(PITCH_LIM_Q13)) ang_new = -28'(PITCH_LIM_Q13);
            if (ang_new > 28'(PITCH_LIM_Q13)) ang_new = 28'(PITCH_LIM_Q13);
            pitch_in = ang_new[14:0];
         end
         ST_DIFF: begin
            half_in = ab_x[32] | ab_x[31] | ab_y[32] | ab_y[31] | ab_z[32] | ab_z[31];
            ax_in = half_in ? ab_x[31:1] : ab_x[30:0];
            ay_in = half_in ? ab_y[31:1] : ab_y[30:0];
            az_in = half_in ? ab_z[31:1] : ab_z[30:0];
         end
         ST_SQX: begin
            mul_a = $signed({2'b00, ax_ff}); mul_b = $signed({2'b00, ax_ff});
         end
         ST_SQY: begin
            acc_in = prod_ff[63:0];
            mul_a = $signed({2'b00, ay_ff}); mul_b = $signed({2'b00, ay_ff});
         end
         ST_SQZ: begin
            acc_in = acc_ff + prod_ff[63:0];
            mul_a = $signed({2'b00, az_ff}); mul_b = $signed({2'b00, az_ff});
         end
         ST_SQSUM: begin
            v_in = acc_ff + prod_ff[63:0];
            r_in = '0;
            bit_in = 64'd1 << 62;
         end
         ST_SQRT: begin
            if (v_ff >= trial) begin
               v_in = v_ff - trial;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         ST_RAD: begin
            rr_in = (r_sh[32] | r_sh[31]) ? 31'h7FFF_FFFF : r_sh[30:0];
            phase_in = 1'b0;
         end
         ST_CINIT: begin
            neg_in = 1'b0;
            if (fold > HALF_PI_Q13) begin
               fold = fold - PI_Q13; neg_in = 1'b1;
            end else if (fold < -HALF_PI_Q13) begin
               fold = fold + PI_Q13; neg_in = 1'b1;
            end
            cx_in = GAIN_Q30;
            cyv_in = '0;
            cz_in = 34'(fold) <<< 17;
            it_in = '0;
         end
         ST_CITER: begin
            cx_in = x_nx;
            cyv_in = y_nx;
            cz_in = cz_ff[33] ? cz_ff + 34'(at) : cz_ff - 34'(at);
            it_in = it_ff + 1'b1;
            if (it_ff == IT_LAST) begin
               if (phase_ff) begin
                  cos_p_in = neg_ff ? 33'(-x_nx) : 33'(x_nx);
                  sin_p_in = neg_ff ? 33'(-y_nx) : 33'(y_nx);
               end else begin
                  cos_y_in = neg_ff ? 33'(-x_nx) : 33'(x_nx);
                  sin_y_in = neg_ff ? 33'(-y_nx) : 33'(y_nx);
               end
               phase_in = 1'b1;
            end
         end
         ST_M1: begin
            mul_a = $signed({2'b00, rr_ff}); mul_b = cos_p_ff;
         end
         ST_M2: begin
            rcp_in = rnd[32:0];
            mul_a = $signed({2'b00, rr_ff}); mul_b = sin_p_ff;
         end
         ST_M3: begin
            pos_sum = 37'(cty_ff) + 37'(rnd);
            mul_a = rcp_ff; mul_b = cos_y_ff;
         end
         ST_M4: begin
            pos_sum = 37'(ctx_ff) + 37'(rnd);
            mul_a = rcp_ff; mul_b = sin_y_ff;
         end
         ST_M5: begin
            pos_sum = 37'(ctz_ff) + 37'(rnd);
         end
         ST_OUT: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1;
               o_x_in = cam_x_ff; o_y_in = cam_y_ff; o_z_in = cam_z_ff;
               o_yaw_in = yaw_ff; o_pitch_in = pitch_ff;
            end
         end
         default: ;
      endcase

      // saturate a new coordinate to 32 bits
      if (pos_sum > 37'sh7FFF_FFFF) pos_sat = 32'sh7FFF_FFFF;
      else if (pos_sum < -37'sh8000_0000) pos_sat = -32'sh8000_0000;
      else pos_sat = pos_sum[31:0];
      if (state_ff == ST_M3) cam_y_in = pos_sat;
      if (state_ff == ST_M4) cam_x_in = pos_sat;
      if (state_ff == ST_M5) cam_z_in = pos_sat;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sens_ff  <= SENS_RESET;
         yaw_ff   <= '0;
         pitch_ff <= '0;
         cam_x_ff <= CAM_RESET;
         cam_y_ff <= CAM_RESET;
         cam_z_ff <= CAM_RESET;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sens_ff  <= sens_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         cam_x_ff <= cam_x_in;
         cam_y_ff <= cam_y_in;
         cam_z_ff <= cam_z_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      kind_ff <= kind_in; dx_ff <= dx_in; dy_ff <= dy_in;
      ctx_ff <= ctx_in; cty_ff <= cty_in; ctz_ff <= ctz_in;
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in; half_ff <= half_in;
      acc_ff <= acc_in; v_ff <= v_in; r_ff <= r_in; bit_ff <= bit_in; rr_ff <= rr_in;
      cx_ff <= cx_in; cyv_ff <= cyv_in; cz_ff <= cz_in; it_ff <= it_in;
      neg_ff <= neg_in; phase_ff <= phase_in;
      cos_y_ff <= cos_y_in; sin_y_ff <= sin_y_in;
      cos_p_ff <= cos_p_in; sin_p_ff <= sin_p_in; rcp_ff <= rcp_in;
      o_x_ff <= o_x_in; o_y_ff <= o_y_in; o_z_ff <= o_z_in;
      o_yaw_ff <= o_yaw_in; o_pitch_ff <= o_pitch_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_pos_x       = o_x_ff;
   assign rsp_pos_y       = o_y_ff;
   assign rsp_pos_z       = o_z_ff;
   assign rsp_yaw_angle   = o_yaw_ff;
   assign rsp_pitch_angle = o_pitch_ff;

   // an accepted item starts the sequencer
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_YAW1)
      else $error("accepted item did not start the sequencer");

   // yaw stays inside 0..2pi
   a_yaw: assert property (@(posedge clock) disable iff (reset)
      yaw_ff <= 16'(TWO_PI_Q13))
      else $error("yaw out of range");

   // pitch stays clamped
   a_pitch: assert property (@(posedge clock) disable iff (reset)
      pitch_ff <= 15'(PITCH_LIM_Q13) && pitch_ff >= -15'(PITCH_LIM_Q13))
      else $error("pitch out of range");

   // cordic step counter never passes the last iteration
   a_iter: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CITER |-> it_ff <= IT_LAST)
      else $error("cordic step counter overran");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the orbit camera update: random and directed pointer
// items, an internal fixed-point predictor, and per-field result comparison.
// ----------------------------------------------------------------------------
module tb;
   import ocu_pkg::*;

   localparam int TRIG_STEPS = 16;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic [15:0]        yaw;
      logic signed [14:0] pitch;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = 1'b0;
   logic signed [10:0] req_delta_x = '0, req_delta_y = '0;
   logic signed [31:0] req_centre_x = '0, req_centre_y = '0, req_centre_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [15:0] rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;

   orbit_camera_update_top dut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_delta_x(req_delta_x), .req_delta_y(req_delta_y),
      .req_centre_x(req_centre_x), .req_centre_y(req_centre_y),
      .req_centre_z(req_centre_z), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_yaw_angle(rsp_yaw_angle), .rsp_pitch_angle(rsp_pitch_angle)
   );

   // predictor state
   longint   gain_now;
   longint   yaw_now, pitch_now;
   longint   cam_now [3];
   pose_type pose_queue [$];
   int       error_count = 0;
   int       pose_count = 0;
   int       orbit_count = 0;
   int       cycle_count = 0;
   int       stall_left = 0;
   bit       calm = 1'b0;

   initial forever #5 clock = ~clock;

   // floor shift of a signed value
   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
   endfunction

   function automatic longint turn_step(longint gain, longint d);
      longint mag, prod;
      mag = d < 0 ? -d : d;
      prod = (gain * 25736 * mag + 32768) >>> 16;
      return d < 0 ? -prod : prod;
   endfunction

   function automatic longint arc_entry(int i);
      longint tab [10] = '{843314857, 497837829, 263043837, 133525159, 67021688,
                           33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return tab[i];
      if (i <= 30) return 64'sd1 <<< (30 - i);
      return 0;
   endfunction

   // cosine and sine of angle plus pi, Q2.30
   task automatic rotate_half_turn(input longint ang, output longint c, output longint s);
      longint a, x, y, z, xs, ys;
      bit flip;
      a = ang + 25736;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (a > 25736) a -= 51472;
      if (a < -25736) a += 51472;
      if (a > 12868) begin
         a -= 25736; flip = 1'b1;
      end else if (a < -12868) begin
         a += 25736; flip = 1'b1;
      end
      z = a * 131072;
      for (int i = 0; i < TRIG_STEPS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= arc_entry(i);
         end else begin
            x += ys; y -= xs; z += arc_entry(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   // expected pose after one pointer item
   task automatic predict_pose(input bit kind, input longint dx, input longint dy,
                               input longint cx, input longint cy, input longint cz);
      longint y, p, dd [3], rr, cyw, syw, cpt, spt, rcp;
      longint unsigned ab [3], r;
      int k;
      pose_type e;
      y = yaw_now + turn_step(gain_now, dx);
      if (y < 0) y += 51472;
      else if (y > 51472) y -= 51472;
      if (y < 0) y = 0;
      if (y > 51472) y = 51472;
      yaw_now = y;
      p = pitch_now + turn_step(gain_now, dy);
      if (p < -9651) p = -9651;
      if (p > 9651) p = 9651;
      pitch_now = p;
      if (kind) begin
         dd[0] = cam_now[0] - cx; dd[1] = cam_now[1] - cy; dd[2] = cam_now[2] - cz;
         k = 0;
         for (int i = 0; i < 3; i++) ab[i] = dd[i] < 0 ? -dd[i] : dd[i];
         if (ab[0] >= 64'd1 << 31 || ab[1] >= 64'd1 << 31 || ab[2] >= 64'd1 << 31) begin
            for (int i = 0; i < 3; i++) ab[i] >>= 1;
            k = 1;
         end
         r = floor_root(ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2]) << k;
         if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
         rr = longint'(r);
         rotate_half_turn(yaw_now, cyw, syw);
         rotate_half_turn(pitch_now, cpt, spt);
         rcp = q30_mul(rr, cpt);
         cam_now[0] = clip32(cx + q30_mul(rcp, cyw));
         cam_now[1] = clip32(cy + q30_mul(rr, spt));
         cam_now[2] = clip32(cz + q30_mul(rcp, syw));
         orbit_count++;
      end
      e.px = cam_now[0][31:0];
      e.py = cam_now[1][31:0];
      e.pz = cam_now[2][31:0];
      e.yaw = yaw_now[15:0];
      e.pitch = pitch_now[14:0];
      pose_queue.push_back(e);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("tb: mismatch %s got %0d want %0d (pose %0d)", what, got, want, pose_count);
      error_count++;
   endtask

   task automatic idle_burst();
      if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 15)) @(posedge clock);
   endtask

   // send one item and wait until it is taken
   task automatic send_item(input bit kind, input int dx, input int dy,
                            input int cx, input int cy, input int cz);
      idle_burst();
      req_valid <= 1'b1;
      req_kind <= kind;
      req_delta_x <= dx[10:0];
      req_delta_y <= dy[10:0];
      req_centre_x <= cx;
      req_centre_y <= cy;
      req_centre_z <= cz;
      predict_pose(kind, longint'(signed'(dx[10:0])), longint'(signed'(dy[10:0])),
                   cx, cy, cz);
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
      // the block is busy after taking an item
      @(posedge clock);
   endtask

   // wait for drain, then set the gain
   task automatic set_gain(input logic [15:0] g);
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= g;
      @(posedge clock);
      csr_write <= 1'b0;
      gain_now = g;
   endtask

   function automatic int any_centre();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return 0;
      endcase
   endfunction

   // receiver stall in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
      rsp_stall <= (stall_left > 0);
   end

   // result checker
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_queue.size() == 0) report_mismatch("unexpected result", 0, 0);
         else begin
            pose_type e;
            e = pose_queue.pop_front();
            if (rsp_pos_x !== e.px) report_mismatch("pos_x", rsp_pos_x, e.px);
            if (rsp_pos_y !== e.py) report_mismatch("pos_y", rsp_pos_y, e.py);
            if (rsp_pos_z !== e.pz) report_mismatch("pos_z", rsp_pos_z, e.pz);
            if (rsp_yaw_angle !== e.yaw) report_mismatch("yaw", rsp_yaw_angle, e.yaw);
            if (rsp_pitch_angle !== e.pitch)
               report_mismatch("pitch", rsp_pitch_angle, e.pitch);
         end
         pose_count++;
      end
   end

   // field extremes, wrap and clamp cases
   task automatic test_directed();
      send_item(1'b0, 0, 0, 0, 0, 0);
      send_item(1'b1, 0, 0, 0, 0, 0);
      send_item(1'b0, 1023, 1023, 0, 0, 0);
      send_item(1'b1, -1024, -1024, 0, 0, 0);
      send_item(1'b1, -1, 1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
      send_item(1'b1, 5, -3, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
      send_item(1'b1, 0, 0, 0, 0, 0);
      set_gain(16'hFFFF);
      send_item(1'b0, 1023, 1023, 0, 0, 0);
      send_item(1'b1, -1024, 0, 65536, -65536, 0);
      send_item(1'b1, 1023, -1024, 0, 0, 0);
      send_item(1'b0, -1024, 1023, 0, 0, 0);
      set_gain(16'd0);
      send_item(1'b1, 1023, -1024, 32'sh12345678, -32'sh12345678, 7);
      send_item(1'b0, -1024, 1023, -1, -1, -1);
      set_gain(16'd655);
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_item(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                   $urandom_range(0, 2047), any_centre(), any_centre(), any_centre());
      end
   endtask

   task automatic test_gains();
      logic [15:0] gains [5] = '{16'd1, 16'd655, 16'd8000, 16'hFFFF, 16'd0};
      foreach (gains[g]) begin
         set_gain(gains[g]);
         test_random(200);
      end
      set_gain(16'($urandom()));
      test_random(500);
      calm = 1'b1;
      test_random(150);
   endtask

   initial begin
      gain_now = 655;
      yaw_now = 0;
      pitch_now = 0;
      foreach (cam_now[i]) cam_now[i] = 131072;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100);
      test_gains();
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("tb: %0d poses checked, %0d of them orbit moves, over six gain settings",
               pose_count, orbit_count);
      if (error_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule

[files.f]
rtl/ocu_pkg.sv
rtl/orbit_camera_update_top.sv
tb/sv/tb.sv
